@@ design/kdc_pkg.sv @@
// Shared types, key codes and digit helpers for the keypad digital clock.
// No dependencies; imported by every module of the block.
package kdc_pkg;

  localparam int unsigned TpsW      = 8;
  localparam int unsigned CountW    = 7;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 6;
  localparam int unsigned CursorW   = 3;
  localparam int unsigned OutDataW  = 56;

  localparam logic [TpsW-1:0] TpsReset = 8'd15;

  localparam logic [CountW-1:0] SecWrap  = 7'd60;
  localparam logic [CountW-1:0] MinWrap  = 7'd60;
  localparam logic [CountW-1:0] HourWrap = 7'd24;

  localparam logic [CursorW-1:0] CursorFirst = 3'd1;
  localparam logic [CursorW-1:0] CursorLast  = 3'd6;

  localparam logic [7:0] KeySlash  = 8'h2F;
  localparam logic [7:0] KeyStar   = 8'h2A;
  localparam logic [7:0] KeyMinus  = 8'h2D;
  localparam logic [7:0] KeyEqual  = 8'h3D;
  localparam logic [7:0] KeyMode   = 8'h6D;
  localparam logic [7:0] KeyLeft   = 8'h28;
  localparam logic [7:0] KeyRight  = 8'h29;
  localparam logic [7:0] KeyZero   = 8'h30;
  localparam logic [7:0] KeyNine   = 8'h39;

  typedef enum logic {
    TOP_CALC  = 1'b0,
    TOP_CLOCK = 1'b1
  } top_mode_t;

  typedef enum logic [1:0] {
    SUB_RUN   = 2'd0,
    SUB_PAUSE = 2'd1,
    SUB_CLEAR = 2'd2,
    SUB_SET   = 2'd3
  } sub_mode_t;

  typedef enum logic {
    ACT_POLL = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] key;
  } kdc_item_t;

  typedef struct packed {
    logic [DigitW-1:0]  set_second_ones;
    logic [DigitW-1:0]  set_second_tens;
    logic [DigitW-1:0]  set_minute_ones;
    logic [DigitW-1:0]  set_minute_tens;
    logic [DigitW-1:0]  set_hour_ones;
    logic [DigitW-1:0]  set_hour_tens;
    logic [CursorW-1:0] cursor_pos;
    sub_mode_t          clock_mode;
    top_mode_t          top_mode;
    logic [CountW-1:0]  seconds;
    logic [CountW-1:0]  minutes;
    logic [CountW-1:0]  hours;
  } kdc_result_t;

  // Tens digit of a 0..127 count: multiply by 205/2048 instead of dividing.
  function automatic logic [DigitW-1:0] tens_of(input logic [CountW-1:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return DigitW'(prod[14:11]);
  endfunction

  function automatic logic [DigitW-1:0] ones_of(input logic [CountW-1:0] v);
    logic [CountW-1:0] t;
    logic [CountW-1:0] t10;
    t   = CountW'(tens_of(v));
    t10 = CountW'({t, 3'b000}) + CountW'({t, 1'b0});
    return DigitW'(v - t10);
  endfunction

  function automatic logic [CountW-1:0] join_digits(input logic [DigitW-1:0] t,
                                                    input logic [DigitW-1:0] o);
    logic [CountW-1:0] t7;
    t7 = CountW'(t);
    return CountW'({t7, 3'b000}) + CountW'({t7, 1'b0}) + CountW'(o);
  endfunction

endpackage

@@ design/keypad_digital_clock_controller.sv @@
// An accepted item lands in the input register; the state update then writes its result
// into the result buffer, which drives out_tvalid. Throughput: one item per cycle while
// out_tready is high; the two-entry result buffer keeps in_tready up for one stalled
// result. Synchronous active-low reset clears the time, modes, prescaler, cursor
// (to 1), digits and buffers; ticks_per_second resets to 15. Depends on kdc_pkg,
// kdc_time, kdc_out_buf.
module keypad_digital_clock_controller
  import kdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [TpsW-1:0]     cfg_wr_data,   // ticks_per_second
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,      // key
  input  logic                in_tuser,      // action
  output logic                out_tvalid,
  input  logic                out_tready,
  // hours, minutes, seconds, top_mode, clock_mode, cursor_pos, set_hour_tens,
  // set_hour_ones, set_minute_tens, set_minute_ones, set_second_tens,
  // set_second_ones, zero fill
  output logic [OutDataW-1:0] out_tdata
);

  logic [TpsW-1:0] tps_r;
  kdc_item_t       item_r;
  logic            item_valid_r;
  logic            advance;
  logic            buf_full;
  kdc_result_t     step_result, head_result;

  assign advance   = item_valid_r && !buf_full;
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r        <= TpsReset;
      item_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) tps_r <= cfg_wr_data;
      if (in_tready) item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.action <= action_t'(in_tuser);
      item_r.key    <= in_tdata;
    end
  end

  kdc_time u_time (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (advance),
    .item             (item_r),
    .ticks_per_second (tps_r),
    .result           (step_result)
  );

  kdc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (advance),
    .push_data  (step_result),
    .full       (buf_full),
    .head_valid (out_tvalid),
    .pop_ready  (out_tready),
    .head_data  (head_result)
  );

  assign out_tdata = {5'd0,
                      head_result.set_second_ones, head_result.set_second_tens,
                      head_result.set_minute_ones, head_result.set_minute_tens,
                      head_result.set_hour_ones,   head_result.set_hour_tens,
                      head_result.cursor_pos,      head_result.clock_mode,
                      head_result.top_mode,        head_result.seconds,
                      head_result.minutes,         head_result.hours};

endmodule

@@ design/kdc_time.sv @@
// Clock state: prescaler, time counters, mode and digit editor, one item per step.
// Depends on kdc_pkg.
module kdc_time
  import kdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  kdc_item_t        item,
  input  logic [TpsW-1:0]  ticks_per_second,
  output kdc_result_t      result
);

  logic [CountW-1:0]  hour_r, hour_nxt;
  logic [CountW-1:0]  min_r, min_nxt;
  logic [CountW-1:0]  sec_r, sec_nxt;
  top_mode_t          top_r, top_nxt;
  sub_mode_t          sub_r, sub_nxt;
  logic [TpsW-1:0]    pre_r, pre_nxt;
  logic [CursorW-1:0] cursor_r, cursor_nxt;
  logic [DigitW-1:0]  digit_r [NumDigits];
  logic [DigitW-1:0]  digit_nxt [NumDigits];

  always_comb begin
    logic [TpsW:0]      pre_inc;
    logic [CountW-1:0]  s_inc;
    logic [CountW-1:0]  m_inc;
    logic [CountW-1:0]  h_inc;
    logic [CursorW-1:0] idx;

    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    top_nxt    = top_r;
    sub_nxt    = sub_r;
    pre_nxt    = pre_r;
    cursor_nxt = cursor_r;
    digit_nxt  = digit_r;
    pre_inc    = (TpsW+1)'(pre_r) + 1'b1;
    s_inc      = sec_r + 1'b1;
    m_inc      = min_r + 1'b1;
    h_inc      = hour_r + 1'b1;
    idx        = cursor_r - 1'b1;

    if (item.action == ACT_TICK) begin
      pre_nxt = pre_inc[TpsW-1:0];
      if (pre_inc >= (TpsW+1)'(ticks_per_second)) begin
        pre_nxt = '0;
        if (top_r == TOP_CLOCK && sub_r == SUB_RUN) begin
          // carry chain: seconds, then minutes, then hours
          sec_nxt = s_inc;
          if (s_inc >= SecWrap) begin
            sec_nxt = '0;
            min_nxt = m_inc;
            if (m_inc >= MinWrap) begin
              min_nxt  = '0;
              hour_nxt = (h_inc >= HourWrap) ? '0 : h_inc;
            end
          end
        end
      end
    end else if (top_r == TOP_CLOCK) begin
      unique case (sub_r)
        SUB_RUN: begin
          if (item.key == KeySlash) sub_nxt = SUB_PAUSE;
        end
        SUB_PAUSE: begin
          if (item.key == KeySlash) begin
            sub_nxt = SUB_RUN;
          end else if (item.key == KeyStar) begin
            sub_nxt = SUB_CLEAR;
          end else if (item.key == KeyMinus) begin
            digit_nxt[0] = tens_of(hour_r);
            digit_nxt[1] = ones_of(hour_r);
            digit_nxt[2] = tens_of(min_r);
            digit_nxt[3] = ones_of(min_r);
            digit_nxt[4] = tens_of(sec_r);
            digit_nxt[5] = ones_of(sec_r);
            cursor_nxt   = CursorFirst;
            sub_nxt      = SUB_SET;
          end
        end
        SUB_CLEAR: begin
          hour_nxt = '0;
          min_nxt  = '0;
          sec_nxt  = '0;
          sub_nxt  = SUB_PAUSE;
        end
        SUB_SET: begin
          if (item.key == KeyLeft && cursor_r > CursorFirst) cursor_nxt = cursor_r - 1'b1;
          if (item.key == KeyRight && cursor_r < CursorLast) cursor_nxt = cursor_r + 1'b1;
          if (item.key >= KeyZero && item.key <= KeyNine) begin
            digit_nxt[idx] = DigitW'(item.key - KeyZero);
          end
          if (item.key == KeyMinus) begin
            hour_nxt = join_digits(digit_r[0], digit_r[1]);
            min_nxt  = join_digits(digit_r[2], digit_r[3]);
            sec_nxt  = join_digits(digit_r[4], digit_r[5]);
            sub_nxt  = SUB_PAUSE;
          end
        end
        default: sub_nxt = sub_r;
      endcase
      if (item.key == KeyEqual) top_nxt = TOP_CALC;
    end else if (item.key == KeyMode) begin
      top_nxt = TOP_CLOCK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r    <= '0;
      min_r     <= '0;
      sec_r     <= '0;
      top_r     <= TOP_CALC;
      sub_r     <= SUB_RUN;
      pre_r     <= '0;
      cursor_r  <= CursorFirst;
      for (int i = 0; i < NumDigits; i++) digit_r[i] <= '0;
    end else if (step) begin
      hour_r    <= hour_nxt;
      min_r     <= min_nxt;
      sec_r     <= sec_nxt;
      top_r     <= top_nxt;
      sub_r     <= sub_nxt;
      pre_r     <= pre_nxt;
      cursor_r  <= cursor_nxt;
      digit_r   <= digit_nxt;
    end
  end

  // the result shows the state after the item
  always_comb begin
    result.hours           = hour_nxt;
    result.minutes         = min_nxt;
    result.seconds         = sec_nxt;
    result.top_mode        = top_nxt;
    result.clock_mode      = sub_nxt;
    result.cursor_pos      = cursor_nxt;
    result.set_hour_tens   = digit_nxt[0];
    result.set_hour_ones   = digit_nxt[1];
    result.set_minute_tens = digit_nxt[2];
    result.set_minute_ones = digit_nxt[3];
    result.set_second_tens = digit_nxt[4];
    result.set_second_ones = digit_nxt[5];
  end

endmodule

@@ design/kdc_out_buf.sv @@
// Two-entry result buffer: output register plus a skid entry.
// Depends on kdc_pkg.
module kdc_out_buf
  import kdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  kdc_result_t push_data,
  output logic        full,
  output logic        head_valid,
  input  logic        pop_ready,
  output kdc_result_t head_data
);

  kdc_result_t head_r, skid_r;
  logic        head_valid_r, skid_valid_r;
  logic        pop;

  assign pop = head_valid_r && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      if (head_valid_r) skid_valid_r <= 1'b1;
      else head_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) head_r <= skid_r;
      else if (push) head_r <= push_data;
    end else if (push) begin
      if (head_valid_r) skid_r <= push_data;
      else head_r <= push_data;
    end
  end

  assign full       = skid_valid_r;
  assign head_valid = head_valid_r;
  assign head_data  = head_r;

endmodule

@@ design/kdc_checker.sv @@
// Port-level checks for the keypad digital clock, bound to the top level.
// Depends on kdc_pkg.
module kdc_checker
  import kdc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_wr_en,
  input logic [TpsW-1:0]     cfg_wr_data,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [7:0]          in_tdata,
  input logic                in_tuser,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // an empty result side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with no pending result");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26:24] != 3'd0 && out_tdata[26:24] <= 3'd6)
    else $error("cursor out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] <= 7'd99 && out_tdata[13:7] <= 7'd99
                   && out_tdata[20:14] <= 7'd99)
    else $error("time counter above 99");

  // an accepted item is followed by a valid result once it has passed the input register and the result buffer
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 1'b1 |=> out_tvalid)
    else $error("accepted item produced no result");

endmodule

bind keypad_digital_clock_controller kdc_checker u_kdc_checker (.*);
